// ===== rtl/lwf_pkg.sv =====
// lwf_pkg: shared constants, register map and the result record type of the
// laplacian window filter. Used by lwf_conv, lwf_out_queue and the top level.
`timescale 1ns / 1ps

package lwf_pkg;

   // geometry and pixel constants
   localparam int DEF_MAX_WIDTH = 1024;
   localparam int KERNEL_SIZE   = 3;
   localparam int TAPS          = KERNEL_SIZE * KERNEL_SIZE;
   localparam int WIN_REGS      = KERNEL_SIZE * (KERNEL_SIZE - 1);
   localparam int PIX_W         = 8;
   localparam int COEF_W        = 6;
   localparam int PROD_W        = PIX_W + 1 + COEF_W;
   localparam int SUM_W         = PROD_W + 4;
   localparam int MID_GRAY      = 128;
   localparam int PIX_MAX       = 255;

   // register map (index = byte address / 8)
   localparam int CSR_ADDR_W = 5;
   localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_KERNEL_COEFFS = 2'd2;

   localparam logic [10:0] DEF_IMAGE_WIDTH  = 11'd640;
   localparam logic [11:0] DEF_IMAGE_HEIGHT = 12'd480;
   // -1 in every tap, 8 in the center tap
   localparam logic [53:0] DEF_KERNEL       = 54'h3F_FFFF_C8FF_FFFF;

   // output queue; depth must be a power of two
   localparam int QUEUE_DEPTH = 8;

   // one accepted pixel and the results it causes
   typedef struct packed {
      logic        emit_win;   // interior center one row up, one column left
      logic        emit_self;  // the pixel itself, on the border
      logic [11:0] row;
      logic [9:0]  col;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic [7:0]  filt;       // clamped filter value of the window
   } lwf_rec_type;

endpackage

// ===== rtl/lwf_conv.sv =====
// lwf_conv: two-stage 3x3 multiply-accumulate on red samples, with mid-gray
// offset and clamping. Depends on lwf_pkg.
`timescale 1ns / 1ps

module lwf_conv
   import lwf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  lwf_rec_type           in_rec,
   input  logic [TAPS*PIX_W-1:0] px,      // tap k at bits 8k+7..8k, row-major
   input  logic [53:0]           coeffs,
   output logic                  out_valid,
   output lwf_rec_type           out_rec
);

   logic signed [PROD_W-1:0] prod_in [TAPS];
   logic signed [PROD_W-1:0] prod_ff [TAPS];
   logic                     valid_ff;
   lwf_rec_type              rec_ff;
   logic signed [SUM_W-1:0]  sum;

   // stage 1: nine small products
   always_comb begin
      for (int k = 0; k < TAPS; k++) begin
         prod_in[k] = $signed({1'b0, px[k*PIX_W +: PIX_W]})
                      * $signed(coeffs[k*COEF_W +: COEF_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= in_rec;
      for (int k = 0; k < TAPS; k++) begin
         prod_ff[k] <= prod_in[k];
      end
   end

   // stage 2: sum, offset, clamp
   always_comb begin
      sum = SUM_W'(MID_GRAY);
      for (int k = 0; k < TAPS; k++) begin
         sum = sum + SUM_W'(prod_ff[k]);
      end
      out_rec = rec_ff;
      if (sum < 0) begin
         out_rec.filt = '0;
      end else if (sum > SUM_W'(PIX_MAX)) begin
         out_rec.filt = PIX_W'(PIX_MAX);
      end else begin
         out_rec.filt = sum[PIX_W-1:0];
      end
   end

   assign out_valid = valid_ff;

endmodule

// ===== rtl/lwf_out_queue.sv =====
// lwf_out_queue: record queue in front of the result channel; expands each
// record into one or two result items. Depends on lwf_pkg.
`timescale 1ns / 1ps

module lwf_out_queue
   import lwf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  lwf_rec_type push_rec,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // out_row[11:0], out_col[21:12], blue_out[29:22],
                                    // green_out[37:30], red_out[45:38], zero[47:46]
   output logic        rsp_tlast,   // last_of_run
   output logic        done         // a record has been fully delivered
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   lwf_rec_type      rec_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             phase_ff, phase_in;   // 1 once the window item of a pair went out
   lwf_rec_type      head;
   logic             show_win;
   logic             fire;
   logic [11:0]      o_row;
   logic [9:0]       o_col;
   logic [7:0]       o_b, o_g, o_r;

   assign head       = rec_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign show_win   = head.emit_win & ~phase_ff;
   assign rsp_tlast  = ~(show_win & head.emit_self);
   assign fire       = rsp_tvalid & rsp_tready;
   assign done       = fire & rsp_tlast;

   // select window result or the pixel itself
   always_comb begin
      if (show_win) begin
         o_row = head.row - 12'd1;
         o_col = head.col - 10'd1;
         o_b   = head.filt;
         o_g   = head.filt;
         o_r   = head.filt;
      end else begin
         o_row = head.row;
         o_col = head.col;
         o_b   = head.blue;
         o_g   = head.green;
         o_r   = head.red;
      end
   end

   assign rsp_tdata = {2'b00, o_r, o_g, o_b, o_col, o_row};

   // pointers, fill count, phase
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = done ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(done);
      phase_in  = phase_ff;
      if (done) begin
         phase_in = 1'b0;
      end else if (fire) begin
         phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         phase_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         phase_ff  <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rec_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

// ===== rtl/laplacian_window_filter.sv =====
// laplacian_window_filter: top level with raster counters, line buffer memory,
// window registers and the configuration port. Depends on lwf_pkg, lwf_conv,
// lwf_out_queue.
// Usage: BGR pixels enter in raster order on req_ (one item per pixel). Each
// interior pixel is replaced by clamp(sum(k*red) + 128) in all three channels;
// border pixels pass unchanged. A pixel item gives zero, one or two result
// items on rsp_: first the finished interior center one row up and one column
// left, then the pixel itself if on the border; tlast marks the last one.
// Throughput: one pixel per cycle while results keep pace; the result side moves
// one item per cycle while rsp_tready is high, so a long run of two-result pixels
// (last row) fills the 8-record queue and input then waits on queue space.
// Path: the first result of a pixel is valid after the line buffer read, the
// product stage, and the sum and clamp into the queue.
// The two line buffers share one 16-bit memory; a same-column read right
// behind its write (image width 1) is served from a forwarding register.
// Reset clears counters, window and queue, not the line buffer; only entries
// written earlier in the frame feed a window result. Stall: with rsp_tready
// low, req_tready drops once 8 pixels are outstanding; nothing is lost.
// Configuration: image_width 0x00, image_height 0x08, kernel_coeffs 0x10; the user
// must write these only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps

module laplacian_window_filter
   import lwf_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel input
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // blue_in[7:0], green_in[15:8], red_in[23:16]
   // result output
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [47:0]           rsp_tdata,   // out_row[11:0], out_col[21:12],
                                              // blue_out[29:22], green_out[37:30],
                                              // red_out[45:38], zero[47:46]
   output logic                  rsp_tlast,   // last_of_run
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [63:0]           csr_pwdata,
   output logic [63:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int CMP_W  = COL_W + 12;
   localparam int CRED_W = $clog2(QUEUE_DEPTH + 1);

   logic [10:0]       image_width_ff;
   logic [11:0]       image_height_ff;
   logic [53:0]       kernel_ff;
   logic [1:0]        reg_idx;
   logic              csr_wr;

   logic              accept;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [11:0]       row_ff, row_in;
   logic [CRED_W-1:0] credit_ff, credit_in;
   logic [CMP_W-1:0]  w_ext, w_eff, c_ext;
   logic [11:0]       h_eff;
   logic              last_col, last_row;
   logic [COL_W+9:0]  col_wide;
   lwf_rec_type       acc_rec;

   logic              s1_valid_ff;
   logic [COL_W-1:0]  s1_col_ff;
   lwf_rec_type       s1_rec_ff;

   logic [15:0]       line_mem_ff [MAX_WIDTH];   // {row two above, row above}
   logic [15:0]       mem_q_ff;
   logic              fwd_ff;
   logic [15:0]       fwd_data_ff;
   logic [15:0]       line_word;
   logic [7:0]        top, mid;
   logic [7:0]        win_ff [WIN_REGS];
   logic [TAPS*PIX_W-1:0] px;

   logic              conv_valid;
   lwf_rec_type       conv_rec;
   logic              q_push, q_drop, q_done;

   // configuration port
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:3];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= DEF_IMAGE_WIDTH;
         image_height_ff <= DEF_IMAGE_HEIGHT;
         kernel_ff       <= DEF_KERNEL;
      end else if (csr_wr) begin
         case (reg_idx)
            REG_IMAGE_WIDTH:   image_width_ff  <= csr_pwdata[10:0];
            REG_IMAGE_HEIGHT:  image_height_ff <= csr_pwdata[11:0];
            REG_KERNEL_COEFFS: kernel_ff       <= csr_pwdata[53:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_IMAGE_WIDTH:   csr_prdata = 64'(image_width_ff);
         REG_IMAGE_HEIGHT:  csr_prdata = 64'(image_height_ff);
         REG_KERNEL_COEFFS: csr_prdata = 64'(kernel_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // input acceptance against outstanding-record credit
   assign req_tready = (credit_ff < CRED_W'(QUEUE_DEPTH));
   assign accept     = req_tvalid & req_tready;

   // effective frame size and border flags
   always_comb begin
      w_ext = CMP_W'(image_width_ff);
      if (w_ext == '0) begin
         w_eff = CMP_W'(1);
      end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
         w_eff = CMP_W'(MAX_WIDTH);
      end else begin
         w_eff = w_ext;
      end
      h_eff    = (image_height_ff == '0) ? 12'd1 : image_height_ff;
      c_ext    = CMP_W'(col_ff);
      last_col = (c_ext >= w_eff - CMP_W'(1));
      last_row = (row_ff >= h_eff - 12'd1);
      col_wide = {10'b0, col_ff};

      acc_rec.emit_win  = (row_ff >= 12'd2) && (c_ext >= CMP_W'(2));
      acc_rec.emit_self = (row_ff == '0) || last_row || (col_ff == '0) || last_col;
      acc_rec.row       = row_ff;
      acc_rec.col       = col_wide[9:0];
      acc_rec.blue      = req_tdata[7:0];
      acc_rec.green     = req_tdata[15:8];
      acc_rec.red       = req_tdata[23:16];
      acc_rec.filt      = '0;
   end

   // raster counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 12'd1;
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
      credit_in = credit_ff + CRED_W'(accept) - CRED_W'(q_drop) - CRED_W'(q_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         credit_ff   <= '0;
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         credit_ff   <= credit_in;
         s1_valid_ff <= accept;
         fwd_ff      <= s1_valid_ff & (s1_col_ff == col_ff);
      end
   end

   always_ff @(posedge clock) begin
      s1_col_ff   <= col_ff;
      s1_rec_ff   <= acc_rec;
      fwd_data_ff <= {mid, s1_rec_ff.red};
   end

   // line buffer: read at accept, written back in the following cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         mem_q_ff <= line_mem_ff[col_ff];
      end
      if (s1_valid_ff) begin
         line_mem_ff[s1_col_ff] <= {mid, s1_rec_ff.red};
      end
   end

   assign line_word = fwd_ff ? fwd_data_ff : mem_q_ff;
   assign top       = line_word[15:8];
   assign mid       = line_word[7:0];

   // 3x3 window, tap 0 lowest
   assign px = {s1_rec_ff.red, win_ff[5], win_ff[4],
                mid,           win_ff[3], win_ff[2],
                top,           win_ff[1], win_ff[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN_REGS; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= top;
         win_ff[2] <= win_ff[3];
         win_ff[3] <= mid;
         win_ff[4] <= win_ff[5];
         win_ff[5] <= s1_rec_ff.red;
      end
   end

   lwf_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_rec    (s1_rec_ff),
      .px        (px),
      .coeffs    (kernel_ff),
      .out_valid (conv_valid),
      .out_rec   (conv_rec)
   );

   // records with no result release their credit here
   assign q_push = conv_valid & (conv_rec.emit_win | conv_rec.emit_self);
   assign q_drop = conv_valid & ~(conv_rec.emit_win | conv_rec.emit_self);

   lwf_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_rec   (conv_rec),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .done       (q_done)
   );

   // checks
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CRED_W'(QUEUE_DEPTH))
      else $error("outstanding pixel count above queue depth");

   a_result_has_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> credit_ff != '0)
      else $error("result shown with no pixel outstanding");

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted pixel missing from read stage");

   a_forward: assert property (@(posedge clock) disable iff (reset)
      (accept && s1_valid_ff && s1_col_ff == col_ff) |=> fwd_ff)
      else $error("same-column read behind write not forwarded");

endmodule
